[rtl/core/tps_pkg.sv]
// tps_pkg: shared constants, configuration and control types for the touch
// point calibration and smoothing block; no dependencies
package tps_pkg;

    // field widths
    localparam int RAW_W      = 12;
    localparam int PX_W       = 9;
    localparam int PY_W       = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // default screen geometry
    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 240;

    // calibration reset values
    localparam logic [RAW_W-1:0] RAW_MIN_RST = 12'd200;
    localparam logic [RAW_W-1:0] RAW_MAX_RST = 12'd3800;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_MAX_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_MIN_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_MAX_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_AXES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_X  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_Y  = 3'd6;

    // divide by three as multiply by reciprocal, exact for values below 2^17
    localparam logic [15:0] DIV3_MUL   = 16'd43691;
    localparam int          DIV3_SHIFT = 17;

    typedef struct packed {
        logic [RAW_W-1:0] raw_min_x;
        logic [RAW_W-1:0] raw_max_x;
        logic [RAW_W-1:0] raw_min_y;
        logic [RAW_W-1:0] raw_max_y;
        logic             swap_axes;
        logic             mirror_x;
        logic             mirror_y;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_MAP,
        S_POST
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic mul_load;
        logic div_step;
        logic map_load;
        logic post;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_valid;
        logic touched;
        logic out_free;
    } t_stat;

endpackage

[rtl/core/tps_in_if.sv]
// tps_in_if: input channel carrying one touch controller poll per item
// depends on nothing
interface tps_in_if;
    logic        valid;
    logic        ready;
    logic        touched;
    logic [11:0] first_raw_x;
    logic [11:0] first_raw_y;
    logic [11:0] second_raw_x;
    logic [11:0] second_raw_y;

    modport source (
        output valid, touched, first_raw_x, first_raw_y, second_raw_x, second_raw_y,
        input  ready
    );
    modport sink (
        input  valid, touched, first_raw_x, first_raw_y, second_raw_x, second_raw_y,
        output ready
    );
endinterface

[rtl/core/tps_out_if.sv]
// tps_out_if: output channel carrying one screen point per item
// depends on nothing
interface tps_out_if;
    logic       valid;
    logic       ready;
    logic [8:0] point_x;
    logic [7:0] point_y;
    logic       pressed;

    modport source (
        output valid, point_x, point_y, pressed,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, pressed,
        output ready
    );
endinterface

[rtl/core/tps_cfg.sv]
// tps_cfg: calibration and orientation registers behind a plain write port
// depends on tps_pkg
module tps_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wen,
    input  logic [tps_pkg::CFG_IDX_W-1:0]     i_index,
    input  logic [tps_pkg::CFG_DATA_W-1:0]    i_wdata,
    output tps_pkg::t_cfg                     o_cfg
);

    tps_pkg::t_cfg r_cfg;
    tps_pkg::t_cfg n_cfg;

    // register decode, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_wen) begin
            case (i_index)
                tps_pkg::CFG_RAW_MIN_X: n_cfg.raw_min_x = i_wdata[tps_pkg::RAW_W-1:0];
                tps_pkg::CFG_RAW_MAX_X: n_cfg.raw_max_x = i_wdata[tps_pkg::RAW_W-1:0];
                tps_pkg::CFG_RAW_MIN_Y: n_cfg.raw_min_y = i_wdata[tps_pkg::RAW_W-1:0];
                tps_pkg::CFG_RAW_MAX_Y: n_cfg.raw_max_y = i_wdata[tps_pkg::RAW_W-1:0];
                tps_pkg::CFG_SWAP_AXES: n_cfg.swap_axes = i_wdata[0];
                tps_pkg::CFG_MIRROR_X:  n_cfg.mirror_x  = i_wdata[0];
                tps_pkg::CFG_MIRROR_Y:  n_cfg.mirror_y  = i_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.raw_min_x <= tps_pkg::RAW_MIN_RST;
            r_cfg.raw_max_x <= tps_pkg::RAW_MAX_RST;
            r_cfg.raw_min_y <= tps_pkg::RAW_MIN_RST;
            r_cfg.raw_max_y <= tps_pkg::RAW_MAX_RST;
            r_cfg.swap_axes <= 1'b0;
            r_cfg.mirror_x  <= 1'b0;
            r_cfg.mirror_y  <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/tps_div.sv]
// tps_div: restoring unsigned divider, one quotient bit per step
// depends on nothing
module tps_div #(
    parameter int N = 21,
    parameter int D = 12
) (
    input  logic         i_clk,
    input  logic         i_load,
    input  logic         i_step,
    input  logic [N-1:0] i_dividend,
    input  logic [D-1:0] i_divisor,
    output logic [N-1:0] o_quotient
);

    logic [N-1:0] r_quo;
    logic [D-1:0] r_rem;
    logic [D-1:0] r_div;
    logic [D:0]   shifted;
    logic [D:0]   diff;
    logic         ge;

    // shift in the next dividend bit and try a subtract
    assign shifted = {r_rem, r_quo[N-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign ge      = (shifted >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (i_step) begin
            r_quo <= {r_quo[N-2:0], ge};
            r_rem <= ge ? diff[D-1:0] : shifted[D-1:0];
        end
    end

    assign o_quotient = r_quo;

endmodule

[rtl/core/tps_ctrl.sv]
// tps_ctrl: sequencer for one poll: multiply, divide steps, map, commit;
// a released poll skips the divide steps and the map; depends on tps_pkg
module tps_ctrl #(
    parameter int STEPS = 21
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tps_pkg::t_stat i_stat,
    output tps_pkg::t_cmd  o_cmd
);

    localparam int CW = $clog2(STEPS);

    tps_pkg::t_state r_state;
    tps_pkg::t_state n_state;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   n_cnt;
    logic            div_done;

    assign div_done = (r_cnt == CW'(STEPS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tps_pkg::S_IDLE: if (i_stat.in_valid) n_state = tps_pkg::S_MUL;
            tps_pkg::S_MUL:  n_state = i_stat.touched ? tps_pkg::S_DIV : tps_pkg::S_POST;
            tps_pkg::S_DIV:  if (div_done) n_state = tps_pkg::S_MAP;
            tps_pkg::S_MAP:  n_state = tps_pkg::S_POST;
            tps_pkg::S_POST: if (i_stat.out_free) n_state = tps_pkg::S_IDLE;
            default:         n_state = tps_pkg::S_IDLE;
        endcase
    end

    // divide step counter
    always_comb begin
        n_cnt = r_cnt;
        if (r_state == tps_pkg::S_MUL) begin
            n_cnt = '0;
        end else if (r_state == tps_pkg::S_DIV) begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    // commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            tps_pkg::S_IDLE: o_cmd.in_ready = 1'b1;
            tps_pkg::S_MUL:  o_cmd.mul_load = 1'b1;
            tps_pkg::S_DIV:  o_cmd.div_step = 1'b1;
            tps_pkg::S_MAP:  o_cmd.map_load = 1'b1;
            tps_pkg::S_POST: o_cmd.post     = i_stat.out_free;
            default:         o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tps_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

[rtl/core/tps_dpath.sv]
// tps_dpath: averaging, calibration map with two divider lanes, mirror,
// clamp, smoothing and output register; depends on tps_pkg, tps_div, channels
module tps_dpath #(
    parameter int SCREEN_WIDTH  = tps_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tps_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tps_pkg::t_cfg  i_cfg,
    input  tps_pkg::t_cmd  i_cmd,
    output tps_pkg::t_stat o_stat,
    tps_in_if.sink         i_in,
    tps_out_if.source      o_out
);

    localparam int RW = tps_pkg::RAW_W;
    localparam int XW = $clog2(SCREEN_WIDTH);
    localparam int YW = $clog2(SCREEN_HEIGHT);
    localparam int MW = (XW > YW) ? XW : YW;
    localparam int DW = RW + MW;
    localparam int VW = DW + 2;
    localparam int PXW = tps_pkg::PX_W;
    localparam int PYW = tps_pkg::PY_W;

    localparam logic [XW-1:0]        TOP_X  = XW'(SCREEN_WIDTH - 1);
    localparam logic [YW-1:0]        TOP_Y  = YW'(SCREEN_HEIGHT - 1);
    localparam logic signed [VW-1:0] TOP_XV = VW'(SCREEN_WIDTH - 1);
    localparam logic signed [VW-1:0] TOP_YV = VW'(SCREEN_HEIGHT - 1);

    // input capture: average the two samples, swap if asked
    logic          accept;
    logic [RW:0]   sum_x, sum_y;
    logic [RW-1:0] avg_x, avg_y;
    logic          r_touched;
    logic [RW-1:0] r_sx, r_sy;

    assign i_in.ready = i_cmd.in_ready;
    assign accept     = i_cmd.in_ready & i_in.valid;
    assign sum_x      = {1'b0, i_in.first_raw_x} + {1'b0, i_in.second_raw_x};
    assign sum_y      = {1'b0, i_in.first_raw_y} + {1'b0, i_in.second_raw_y};
    assign avg_x      = sum_x[RW:1];
    assign avg_y      = sum_y[RW:1];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_touched <= i_in.touched;
            r_sx      <= i_cfg.swap_axes ? avg_y : avg_x;
            r_sy      <= i_cfg.swap_axes ? avg_x : avg_y;
        end
    end

    // offset and span magnitudes, product feeds the dividers
    logic [RW-1:0]    lo_x, hi_x, lo_y, hi_y;
    logic [RW:0]      dif_x, dif_y, spn_x, spn_y;
    logic [RW:0]      ndif_x, ndif_y, nspn_x, nspn_y;
    logic [RW-1:0]    mdif_x, mdif_y, mspn_x, mspn_y;
    logic [RW+XW-1:0] prod_x;
    logic [RW+YW-1:0] prod_y;
    logic             r_neg_x, r_neg_y, r_zero_x, r_zero_y;
    logic [DW-1:0]    quo_x, quo_y;

    assign lo_x = i_cfg.swap_axes ? i_cfg.raw_min_y : i_cfg.raw_min_x;
    assign hi_x = i_cfg.swap_axes ? i_cfg.raw_max_y : i_cfg.raw_max_x;
    assign lo_y = i_cfg.swap_axes ? i_cfg.raw_min_x : i_cfg.raw_min_y;
    assign hi_y = i_cfg.swap_axes ? i_cfg.raw_max_x : i_cfg.raw_max_y;

    assign dif_x  = {1'b0, r_sx} - {1'b0, lo_x};
    assign dif_y  = {1'b0, r_sy} - {1'b0, lo_y};
    assign spn_x  = {1'b0, hi_x} - {1'b0, lo_x};
    assign spn_y  = {1'b0, hi_y} - {1'b0, lo_y};
    assign ndif_x = ~dif_x + 1'b1;
    assign ndif_y = ~dif_y + 1'b1;
    assign nspn_x = ~spn_x + 1'b1;
    assign nspn_y = ~spn_y + 1'b1;
    assign mdif_x = dif_x[RW] ? ndif_x[RW-1:0] : dif_x[RW-1:0];
    assign mdif_y = dif_y[RW] ? ndif_y[RW-1:0] : dif_y[RW-1:0];
    assign mspn_x = spn_x[RW] ? nspn_x[RW-1:0] : spn_x[RW-1:0];
    assign mspn_y = spn_y[RW] ? nspn_y[RW-1:0] : spn_y[RW-1:0];
    assign prod_x = mdif_x * TOP_X;
    assign prod_y = mdif_y * TOP_Y;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_neg_x  <= dif_x[RW] ^ spn_x[RW];
            r_neg_y  <= dif_y[RW] ^ spn_y[RW];
            r_zero_x <= (spn_x == '0);
            r_zero_y <= (spn_y == '0);
        end
    end

    tps_div #(.N(DW), .D(RW)) u_div_x (
        .i_clk      (i_clk),
        .i_load     (i_cmd.mul_load),
        .i_step     (i_cmd.div_step),
        .i_dividend (DW'(prod_x)),
        .i_divisor  (mspn_x),
        .o_quotient (quo_x)
    );

    tps_div #(.N(DW), .D(RW)) u_div_y (
        .i_clk      (i_clk),
        .i_load     (i_cmd.mul_load),
        .i_step     (i_cmd.div_step),
        .i_dividend (DW'(prod_y)),
        .i_divisor  (mspn_y),
        .o_quotient (quo_y)
    );

    // sign, empty range, mirror and clamp to the screen
    logic signed [VW-1:0] q_x, q_y, v_x, v_y, m_x, m_y;
    logic [XW-1:0]        c_x, r_mx;
    logic [YW-1:0]        c_y, r_my;

    assign q_x = $signed(VW'(quo_x));
    assign q_y = $signed(VW'(quo_y));
    assign v_x = r_zero_x ? '0 : (r_neg_x ? -q_x : q_x);
    assign v_y = r_zero_y ? '0 : (r_neg_y ? -q_y : q_y);
    assign m_x = i_cfg.mirror_x ? (TOP_XV - v_x) : v_x;
    assign m_y = i_cfg.mirror_y ? (TOP_YV - v_y) : v_y;

    always_comb begin
        if (m_x < 0) begin
            c_x = '0;
        end else if (m_x > TOP_XV) begin
            c_x = TOP_X;
        end else begin
            c_x = m_x[XW-1:0];
        end
        if (m_y < 0) begin
            c_y = '0;
        end else if (m_y > TOP_YV) begin
            c_y = TOP_Y;
        end else begin
            c_y = m_y[YW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.map_load) begin
            r_mx <= c_x;
            r_my <= c_y;
        end
    end

    // smoothing against the held point: x by 3/4 weight, y by 2/3 weight
    logic [XW+1:0]    smo_x;
    logic [YW+1:0]    smo_y;
    logic [YW+17:0]   div3_y;
    logic [XW-1:0]    new_x, r_held_x;
    logic [YW-1:0]    new_y, r_held_y;
    logic             r_active;

    assign smo_x  = {2'b00, r_held_x} + {1'b0, r_mx, 1'b0} + {2'b00, r_mx};
    assign smo_y  = {2'b00, r_held_y} + {1'b0, r_my, 1'b0};
    assign div3_y = smo_y * tps_pkg::DIV3_MUL;
    assign new_x  = r_active ? smo_x[XW+1:2] : r_mx;
    assign new_y  = r_active ? div3_y[tps_pkg::DIV3_SHIFT+YW-1:tps_pkg::DIV3_SHIFT] : r_my;

    // result selection, narrowed to the output field widths
    logic [XW-1:0]     res_x;
    logic [YW-1:0]     res_y;
    logic [XW+PXW-1:0] ext_x;
    logic [YW+PYW-1:0] ext_y;
    logic              r_out_valid;
    logic [PXW-1:0]    r_out_x;
    logic [PYW-1:0]    r_out_y;
    logic              r_out_pressed;

    assign res_x = r_touched ? new_x : r_held_x;
    assign res_y = r_touched ? new_y : r_held_y;
    assign ext_x = {{PXW{1'b0}}, res_x};
    assign ext_y = {{PYW{1'b0}}, res_y};

    // held point and touch tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x <= '0;
            r_held_y <= '0;
            r_active <= 1'b0;
        end else if (i_cmd.post) begin
            r_held_x <= res_x;
            r_held_y <= res_y;
            r_active <= r_touched;
        end
    end

    // output register, frees the front end while a result waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.post) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.post) begin
            r_out_x       <= ext_x[PXW-1:0];
            r_out_y       <= ext_y[PYW-1:0];
            r_out_pressed <= r_touched;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.point_x = r_out_x;
    assign o_out.point_y = r_out_y;
    assign o_out.pressed = r_out_pressed;

    // status
    assign o_stat.in_valid = i_in.valid;
    assign o_stat.touched  = r_touched;
    assign o_stat.out_free = ~r_out_valid | o_out.ready;

endmodule

[rtl/core/touch_point_calibrate_smooth_top.sv]
// touch_point_calibrate_smooth_top: top level of the touch calibration block
// depends on tps_pkg, tps_in_if, tps_out_if, tps_cfg, tps_ctrl, tps_dpath
//
// Each input item is one touch controller poll and gives exactly one result
// item. A touched poll averages the two raw sample pairs, optionally swaps
// the axes, maps each axis from its calibrated raw range to pixels with a
// signed divide that truncates toward zero (an empty range maps to 0),
// optionally mirrors, clamps, and smooths against the held point; the first
// touched poll after a release loads the held point directly. A released
// poll returns the held point with pressed low. A touched poll passes
// through the multiply, the divide steps of the two restoring dividers,
// which resolve one quotient bit per cycle, the map and the commit; a
// released poll goes from the multiply straight to the commit. The
// result sits in an output register, so the next poll is taken while it
// waits; the block only stalls when a second result is ready before the
// first was taken. Configuration writes go through the plain write port;
// the user makes them only while idle; the block does not enforce this.
// point_x and point_y carry the low 9 and 8 bits of the pixel position.
module touch_point_calibrate_smooth_top #(
    parameter int SCREEN_WIDTH  = tps_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = tps_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wen,
    input  logic [tps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tps_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    tps_in_if.sink                         i_in,
    tps_out_if.source                      o_out
);

    localparam int XW    = $clog2(SCREEN_WIDTH);
    localparam int YW    = $clog2(SCREEN_HEIGHT);
    localparam int STEPS = tps_pkg::RAW_W + ((XW > YW) ? XW : YW);

    tps_pkg::t_cfg  cfg;
    tps_pkg::t_cmd  cmd;
    tps_pkg::t_stat stat;

    // configuration registers
    tps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wen   (i_cfg_wen),
        .i_index (i_cfg_index),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    // sequencer
    tps_ctrl #(.STEPS(STEPS)) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // datapath
    tps_dpath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
